// ----- hdl/ess_pkg.sv -----
// Package: types, codes and constants of the engine start sequencer.
package ess_pkg;

	// Glow timer width; glow durations are truncated to it.
	localparam int GLOW_TIMER_BITS = 12;

	localparam int DELAY_BITS = 10;
	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 12;
	localparam int IN_DATA_BITS = 16;
	localparam int OUT_DATA_BITS = 16;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_GLOW    = 3'd1,
		PH_PRIME   = 3'd2,
		PH_STARTER = 3'd3,
		PH_CRANK   = 3'd4,
		PH_CHECK   = 3'd5,
		PH_RUN     = 3'd6,
		PH_FAIL    = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		ST_NONE      = 2'd0,
		ST_WARM      = 2'd1,
		ST_START     = 2'd2,
		ST_ENGINE_ON = 2'd3
	} status_t;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_MAX_ATTEMPTS  = 3'd0,
		REG_PRIME_DELAY   = 3'd1,
		REG_CRANK_TIME    = 3'd2,
		REG_PRESSURE_WAIT = 3'd3,
		REG_POSTHEAT_TIME = 3'd4,
		REG_NO_GLOW_TEMP  = 3'd5
	} cfg_reg_t;

	// Temperature band edges, degrees F
	localparam logic signed [8:0] TEMP_WARM = 9'sd104;
	localparam logic signed [8:0] TEMP_MILD = 9'sd68;
	localparam logic signed [8:0] TEMP_COLD = 9'sd32;

	// Glow durations in ticks
	localparam logic [GLOW_TIMER_BITS-1:0] GLOW_NO_SENSOR = GLOW_TIMER_BITS'(2800);
	localparam logic [GLOW_TIMER_BITS-1:0] GLOW_WARM      = GLOW_TIMER_BITS'(800);
	localparam logic [GLOW_TIMER_BITS-1:0] GLOW_MILD      = GLOW_TIMER_BITS'(1000);
	localparam logic [GLOW_TIMER_BITS-1:0] GLOW_COLD      = GLOW_TIMER_BITS'(1600);
	localparam logic [GLOW_TIMER_BITS-1:0] GLOW_FROST     = GLOW_TIMER_BITS'(2900);

	// Register reset values
	localparam logic [2:0]  RST_MAX_ATTEMPTS  = 3'd5;
	localparam logic [9:0]  RST_PRIME_DELAY   = 10'd100;
	localparam logic [9:0]  RST_CRANK_TIME    = 10'd400;
	localparam logic [9:0]  RST_PRESSURE_WAIT = 10'd1000;
	localparam logic [11:0] RST_POSTHEAT_TIME = 12'd500;
	localparam logic signed [8:0] RST_NO_GLOW_TEMP = 9'sd122;

	localparam logic [2:0] ATTEMPTS_MAX = 3'd7;

endpackage

// ----- hdl/engine_start_sequencer.sv -----
// Top level: diesel engine start sequencer, one request per tick.
//
// Usage:
//  - Slave stream (s_*) takes one tick request: start request, sensor status,
//    outside temperature and oil pressure status. Master stream (m_*) returns
//    one result per request: drive outputs, status, failure flag, phase and
//    attempt count, all as they stand after that tick.
//  - Result path: an accepted request is registered, the sequencer steps once
//    the result slot is free, and the result shows on m_tdata after that step.
//  - Throughput: one request per cycle while m_tready stays high; the single
//    sequencer step between input and result register sets that figure.
//  - When the receiver stalls, the result register holds and the input
//    register keeps one more request; s_tready drops once both are full.
//  - Reset (arst_n low) puts the sequencer idle with drives off, timers
//    expired, attempts and failure flag clear, and all registers at their
//    defaults (5, 100, 400, 1000, 500, 122).
//  - Configuration: cfg_we with cfg_addr/cfg_wdata writes one register per
//    edge; indexes above 5 are ignored. Write only while no request is in
//    flight.
//  - After a failure the drives are held and start_failed stays set until
//    the next start request; shutdown is up to the surrounding logic.
module engine_start_sequencer (
	input  logic                               clk,
	input  logic                               arst_n,
	// s_tdata: start_req[0], temp_sensor_ok[1], temperature[10:2],
	//          oil_pressure_ok[11], zero fill[15:12]
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ess_pkg::IN_DATA_BITS-1:0]   s_tdata,
	// m_tdata: glow drive[0], pump drive[1], starter[2], status[4:3],
	//          start_failed[5], phase[8:6], attempts[11:9], zero fill[15:12]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ess_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	input  logic                               cfg_we,
	input  logic [ess_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
	input  logic [ess_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

	localparam int GB = ess_pkg::GLOW_TIMER_BITS;
	localparam int DB = ess_pkg::DELAY_BITS;

	// ---------------- configuration registers ----------------
	logic [2:0]        max_attempts_q;
	logic [DB-1:0]     prime_delay_q;
	logic [DB-1:0]     crank_time_q;
	logic [DB-1:0]     pressure_wait_q;
	logic [11:0]       postheat_time_q;
	logic signed [8:0] no_glow_temp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_attempts_q  <= ess_pkg::RST_MAX_ATTEMPTS;
			prime_delay_q   <= ess_pkg::RST_PRIME_DELAY;
			crank_time_q    <= ess_pkg::RST_CRANK_TIME;
			pressure_wait_q <= ess_pkg::RST_PRESSURE_WAIT;
			postheat_time_q <= ess_pkg::RST_POSTHEAT_TIME;
			no_glow_temp_q  <= ess_pkg::RST_NO_GLOW_TEMP;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ess_pkg::REG_MAX_ATTEMPTS:  max_attempts_q  <= cfg_wdata[2:0];
				ess_pkg::REG_PRIME_DELAY:   prime_delay_q   <= cfg_wdata[DB-1:0];
				ess_pkg::REG_CRANK_TIME:    crank_time_q    <= cfg_wdata[DB-1:0];
				ess_pkg::REG_PRESSURE_WAIT: pressure_wait_q <= cfg_wdata[DB-1:0];
				ess_pkg::REG_POSTHEAT_TIME: postheat_time_q <= cfg_wdata[11:0];
				ess_pkg::REG_NO_GLOW_TEMP:  no_glow_temp_q  <= $signed(cfg_wdata[8:0]);
				default: ;
			endcase
		end
	end

	// ---------------- input register ----------------
	logic              valid_s1;
	logic              req_s1;
	logic              sensor_ok_s1;
	logic signed [8:0] temp_s1;
	logic              oil_ok_s1;
	logic              advance;

	// the step fires when a request waits and the result slot is free
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1       <= s_tdata[0];
			sensor_ok_s1 <= s_tdata[1];
			temp_s1      <= $signed(s_tdata[10:2]);
			oil_ok_s1    <= s_tdata[11];
		end
	end

	// ---------------- sequencer state ----------------
	ess_pkg::phase_t  phase_q, phase_d;
	ess_pkg::status_t status_q, status_d;
	logic [GB-1:0]    glow_timer_q, glow_timer_d;
	logic [DB-1:0]    delay_timer_q, delay_timer_d;
	logic [2:0]       attempts_q, attempts_d;
	logic             glow_q, glow_d;
	logic             pump_q, pump_d;
	logic             starter_q, starter_d;
	logic             failed_q, failed_d;

	always_comb begin
		// timers tick first
		glow_timer_d  = (glow_timer_q != '0) ? glow_timer_q - GB'(1) : glow_timer_q;
		delay_timer_d = (delay_timer_q != '0) ? delay_timer_q - DB'(1) : delay_timer_q;
		phase_d   = phase_q;
		status_d  = status_q;
		attempts_d = attempts_q;
		glow_d    = glow_q;
		pump_d    = pump_q;
		starter_d = starter_q;
		failed_d  = failed_q;

		// start request restarts at the glow step in this same tick
		if (req_s1) begin
			glow_d     = 1'b0;
			pump_d     = 1'b0;
			starter_d  = 1'b0;
			attempts_d = '0;
			failed_d   = 1'b0;
			phase_d    = ess_pkg::PH_GLOW;
		end

		unique case (phase_d)
			ess_pkg::PH_GLOW: begin
				glow_d   = 1'b1;
				status_d = ess_pkg::ST_WARM;
				if (!sensor_ok_s1) begin
					glow_timer_d = ess_pkg::GLOW_NO_SENSOR;
				end else if (temp_s1 >= no_glow_temp_q) begin
					glow_timer_d = '0;
					glow_d       = 1'b0;
				end else if (temp_s1 >= ess_pkg::TEMP_WARM) begin
					glow_timer_d = ess_pkg::GLOW_WARM;
				end else if (temp_s1 >= ess_pkg::TEMP_MILD) begin
					glow_timer_d = ess_pkg::GLOW_MILD;
				end else if (temp_s1 >= ess_pkg::TEMP_COLD) begin
					glow_timer_d = ess_pkg::GLOW_COLD;
				end else begin
					glow_timer_d = ess_pkg::GLOW_FROST;
				end
				if (attempts_d != ess_pkg::ATTEMPTS_MAX) attempts_d = attempts_d + 3'd1;
				phase_d = ess_pkg::PH_PRIME;
			end
			ess_pkg::PH_PRIME: begin
				if (glow_timer_d == '0) begin
					glow_d = 1'b0;
					if (delay_timer_d == '0) begin
						pump_d        = 1'b1;
						delay_timer_d = prime_delay_q;
						phase_d       = ess_pkg::PH_STARTER;
					end
				end
			end
			ess_pkg::PH_STARTER: begin
				if (delay_timer_d == '0) begin
					starter_d     = 1'b1;
					status_d      = ess_pkg::ST_START;
					delay_timer_d = crank_time_q;
					phase_d       = ess_pkg::PH_CRANK;
				end
			end
			ess_pkg::PH_CRANK: begin
				if (delay_timer_d == '0) begin
					starter_d = 1'b0;
					// post-heat uses the temperature regardless of sensor status
					if (temp_s1 < no_glow_temp_q) begin
						glow_d       = 1'b1;
						glow_timer_d = GB'(postheat_time_q);
					end
					delay_timer_d = pressure_wait_q;
					phase_d       = ess_pkg::PH_CHECK;
				end
			end
			ess_pkg::PH_CHECK: begin
				if (glow_timer_d == '0) glow_d = 1'b0;
				if (delay_timer_d == '0) begin
					if (!oil_ok_s1) begin
						if (attempts_d >= max_attempts_q) begin
							attempts_d = '0;
							failed_d   = 1'b1;
							phase_d    = ess_pkg::PH_FAIL;
						end else begin
							pump_d  = 1'b0;
							phase_d = ess_pkg::PH_GLOW;
						end
					end else begin
						delay_timer_d = '0;
						attempts_d    = '0;
						status_d      = ess_pkg::ST_ENGINE_ON;
						phase_d       = ess_pkg::PH_RUN;
					end
				end
			end
			default: ; // idle, running, failed: hold
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= ess_pkg::PH_IDLE;
			status_q      <= ess_pkg::ST_NONE;
			glow_timer_q  <= '0;
			delay_timer_q <= '0;
			attempts_q    <= '0;
			glow_q        <= 1'b0;
			pump_q        <= 1'b0;
			starter_q     <= 1'b0;
			failed_q      <= 1'b0;
		end else if (advance) begin
			phase_q       <= phase_d;
			status_q      <= status_d;
			glow_timer_q  <= glow_timer_d;
			delay_timer_q <= delay_timer_d;
			attempts_q    <= attempts_d;
			glow_q        <= glow_d;
			pump_q        <= pump_d;
			starter_q     <= starter_d;
			failed_q      <= failed_d;
		end
	end

	// ---------------- result register ----------------
	logic m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	// the state registers double as the result payload
	assign m_tdata  = {4'b0000, attempts_q, phase_q, failed_q, status_q,
		starter_q, pump_q, glow_q};

	// ---------------- assertions ----------------
	// failure flag is set exactly while parked in the failed phase
	a_fail_phase: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q == (phase_q == ess_pkg::PH_FAIL))
		else $error("failure flag out of step with phase");

	// starter runs only in the crank phase
	a_starter_crank: assert property (@(posedge clk) disable iff (!arst_n)
		starter_q == (phase_q == ess_pkg::PH_CRANK))
		else $error("starter drive out of step with phase");

	// resting phases carry no attempt count
	a_attempts_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ess_pkg::PH_IDLE || phase_q == ess_pkg::PH_RUN ||
		 phase_q == ess_pkg::PH_FAIL) |-> (attempts_q == 3'd0))
		else $error("attempt count left set in resting phase");

	// a full input register with a stalled result blocks new requests
	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_tvalid && !m_tready) |-> !s_tready)
		else $error("request taken while pipeline is full");

endmodule
